@@ design/bgp_pkg.sv @@
// Shared types and constants for the bilevel group packer.
package bgp_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned GROUP_SIZE = 4;
  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned WIDTH_W    = 9;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef logic [PIX_W-1:0] pix_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 3'd0,
    CFG_WHITE_LEVEL = 3'd1,
    CFG_BLACK_LEVEL = 3'd2,
    CFG_CODE_WHITE  = 3'd3,
    CFG_CODE_BLACK  = 3'd4,
    CFG_CODE_MIXED  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] image_width;
    pix_t               white_level;
    pix_t               black_level;
    pix_t               code_white;
    pix_t               code_black;
    pix_t               code_mixed;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic                  row_empty;
    pix_t                  code;
    logic [CNT_W-1:0]      count;
    pix_t [GROUP_SIZE-1:0] bytes;
    logic                  row_end;
  } res_t;

  // One request from front to back: a run of held white codes, then a result
  typedef struct packed {
    logic [COL_W-1:0] whites;
    pix_t             fill_code;
    res_t             res;
  } req_t;

  typedef enum logic {
    BK_IDLE,
    BK_BUSY
  } back_state_t;

endpackage

@@ design/bgp_queue.sv @@
// Small register queue that decouples the classifier from the result emitter.
module bgp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ design/bgp_front.sv @@
// Front end: tracks the row position, classifies each group and queues requests.
module bgp_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bgp_pkg::cfg_t                         cfg,
  input  logic                                  fire,
  input  bgp_pkg::pix_t [bgp_pkg::GROUP_SIZE-1:0] pixels,
  output logic                                  push,
  output bgp_pkg::req_t                         req
);
  import bgp_pkg::*;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [COL_W-1:0]   pend_r, pend_nxt;
  logic               has_r, has_nxt;

  logic [WIDTH_W-1:0] w_eff;
  logic [WIDTH_W-1:0] w_m1;
  logic [COL_W-1:0]   last_col;
  logic               last;
  logic [CNT_W-1:0]   valid;
  logic               all_white, all_black;
  pix_t [GROUP_SIZE-1:0] bytes;

  // Effective width: zero reads as one, oversize saturates
  always_comb begin
    priority if (cfg.image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (cfg.image_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg.image_width;
    end
  end

  // Row position: last group and its valid pixel count
  assign w_m1     = w_eff - 1'b1;
  assign last_col = COL_W'(w_m1 >> 2);
  assign last     = (col_r >= last_col);
  assign valid    = last ? (CNT_W'(w_m1[1:0]) + 1'b1) : CNT_W'(GROUP_SIZE);

  // Classification over the valid pixels
  always_comb begin
    all_white = 1'b1;
    all_black = 1'b1;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      bytes[i] = '0;
      if (CNT_W'(i) < valid) begin
        bytes[i] = pixels[i];
        if (pixels[i] != cfg.white_level) all_white = 1'b0;
        if (pixels[i] != cfg.black_level) all_black = 1'b0;
      end
    end
  end

  // Request build and row state update
  always_comb begin
    push              = 1'b0;
    req               = '0;
    req.fill_code     = cfg.code_white;
    req.res.row_end   = last;
    col_nxt           = col_r;
    pend_nxt          = pend_r;
    has_nxt           = has_r;
    if (fire) begin
      if (all_white) begin
        if (has_r) begin
          push         = 1'b1;
          req.res.code = cfg.code_white;
        end else if (last) begin
          push              = 1'b1;
          req.res.row_empty = 1'b1;
        end else begin
          pend_nxt = pend_r + 1'b1;
        end
      end else begin
        push       = 1'b1;
        req.whites = pend_r;
        pend_nxt   = '0;
        has_nxt    = 1'b1;
        if (all_black) begin
          req.res.code = cfg.code_black;
        end else begin
          req.res.code  = cfg.code_mixed;
          req.res.count = valid;
          req.res.bytes = bytes;
        end
      end
      if (last) begin
        col_nxt  = '0;
        pend_nxt = '0;
        has_nxt  = 1'b0;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      pend_r <= '0;
      has_r  <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      pend_r <= pend_nxt;
      has_r  <= has_nxt;
    end
  end

endmodule

@@ design/bgp_back.sv @@
// Back end: expands queued requests into result items behind an output register.
module bgp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  bgp_pkg::req_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output bgp_pkg::res_t out_res
);
  import bgp_pkg::*;

  back_state_t      state_r, state_nxt;
  req_t             work_r;
  logic [COL_W-1:0] rem_r;
  logic             out_valid_r;
  res_t             out_res_r;
  res_t             fill_res;
  logic             out_free;
  logic             emit;
  logic             emit_fill;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Held white code result
  always_comb begin
    fill_res      = '0;
    fill_res.code = work_r.fill_code;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_BUSY;
      BK_BUSY: if (out_free && rem_r == '0) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_fill = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop = !q_empty;
      BK_BUSY: begin
        emit      = out_free;
        emit_fill = (rem_r != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Work request, white run counter and output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_r <= q_data;
      rem_r  <= q_data.whites;
    end else if (emit && emit_fill) begin
      rem_r <= rem_r - 1'b1;
    end
    if (emit) begin
      if (emit_fill) begin
        out_res_r <= fill_res;
      end else begin
        out_res_r <= work_r.res;
      end
    end
  end

endmodule

@@ design/bilevel_group_packer.sv @@
// Top level of the bilevel group packer: configuration registers and stream ports.
//
// Takes one group of four 8-bit pixels per request, row by row, and gives a
// white, black or mixed code per group, with leading white groups of a row
// held back and released before the first non-white group, or replaced by
// one empty-row result when the whole row is white. The front end takes a
// group whenever its request queue has room. The back end loads a queued
// request while idle, then gives one result per cycle while its single
// output register is free: first the held white codes, then the group's own
// result. The user must write configuration only while the block is idle;
// the block itself does not enforce it.
module bilevel_group_packer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_a[7:0], pixel_b[15:8], pixel_c[23:16], pixel_d[31:24]
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // group_code[7:0], payload_count[10:8], byte_a[18:11],
                                  // byte_b[26:19], byte_c[34:27], byte_d[42:35], zero[47:43]
  output logic        out_tlast,  // row_end
  output logic        out_tuser,  // row_empty
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata
);
  import bgp_pkg::*;

  cfg_t             cfg_r;
  logic             q_full, q_empty, q_push, q_pop;
  req_t             q_wr, q_rd;
  logic             in_fire;
  pix_t [GROUP_SIZE-1:0] pixels;
  logic             res_valid;
  res_t             res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width <= WIDTH_W'(MAX_WIDTH);
      cfg_r.white_level <= 8'd255;
      cfg_r.black_level <= 8'd0;
      cfg_r.code_white  <= 8'd0;
      cfg_r.code_black  <= 8'd1;
      cfg_r.code_mixed  <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_IMAGE_WIDTH: cfg_r.image_width <= cfg_wdata;
        CFG_WHITE_LEVEL: cfg_r.white_level <= cfg_wdata[7:0];
        CFG_BLACK_LEVEL: cfg_r.black_level <= cfg_wdata[7:0];
        CFG_CODE_WHITE:  cfg_r.code_white  <= cfg_wdata[7:0];
        CFG_CODE_BLACK:  cfg_r.code_black  <= cfg_wdata[7:0];
        CFG_CODE_MIXED:  cfg_r.code_mixed  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && !q_full;
  assign pixels    = in_tdata;

  bgp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .fire   (in_fire),
    .pixels (pixels),
    .push   (q_push),
    .req    (q_wr)
  );

  bgp_queue #(
    .WIDTH ($bits(req_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  bgp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rd),
    .q_pop     (q_pop),
    .out_valid (res_valid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Result packing
  assign out_tvalid = res_valid;
  assign out_tdata  = {5'd0, res.bytes[3], res.bytes[2], res.bytes[1], res.bytes[0],
                       res.count, res.code};
  assign out_tlast  = res.row_end;
  assign out_tuser  = res.row_empty;

endmodule
